### src/sdc_pkg.sv
// Shared types, constants and defaults for the slave clock dial controller.
package sdc_pkg;

  localparam int DIAL_MINUTES_DEF = 720;

  localparam int TIME_W   = 11;
  localparam int OUT_T_W  = 10;
  localparam int WINDOW_W = 10;
  localparam int WORD_W   = 16;
  localparam int DELTA_W  = 8;
  localparam int TVQ_W    = 10;
  localparam int DLTU_W   = 12;
  localparam int DLTQ_W   = 11;

  localparam int IN_DATA_W  = 40;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 2;

  localparam logic [WINDOW_W-1:0] WAIT_WINDOW_RST = 10'd30;
  localparam logic [TIME_W-1:0]   SAVE_INVALID    = 11'h7ff;
  localparam logic [WORD_W-1:0]   RESTORE_MASK    = 16'hc000;
  localparam int                  POL_BIT         = 11;

  typedef enum logic [2:0] {
    OP_SET        = 3'd0,
    OP_ADJUST     = 3'd1,
    OP_SHIFT      = 3'd2,
    OP_STOP       = 3'd3,
    OP_TICK       = 3'd4,
    OP_PULSE_DONE = 3'd5,
    OP_RESTORE    = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    MODE_INITIAL  = 3'd0,
    MODE_SYNCED   = 3'd1,
    MODE_RUNNING  = 3'd2,
    MODE_HEADLESS = 3'd3,
    MODE_PENDING  = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_PULSE = 2'd1,
    KIND_STORE = 2'd2
  } kind_t;

  typedef struct packed {
    op_t                opcode;
    logic [TIME_W-1:0]  time_value;
    logic [TVQ_W-1:0]   tv_quo;
    logic [DLTU_W-1:0]  dlt_u;
    logic [DLTQ_W-1:0]  dlt_quo;
    logic               driver_busy;
    logic [WORD_W-1:0]  saved_word;
  } item_t;

  typedef struct packed {
    kind_t               result_kind;
    logic                pulse_polarity;
    logic [WORD_W-1:0]   store_word;
    mode_t               mode_now;
    logic [OUT_T_W-1:0]  time_now;
    logic [OUT_T_W-1:0]  dial_now;
  } result_t;

endpackage

### src/sdc_ingress.sv
// Input register with reciprocal quotients for the modulo reductions.
module sdc_ingress #(
  parameter int DIAL_MINUTES = sdc_pkg::DIAL_MINUTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [sdc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  input  logic [sdc_pkg::IN_USER_W-1:0]    s_axis_tuser,
  input  logic                             advance,
  output logic                             fire,
  output sdc_pkg::item_t                   item
);

  localparam int TV_SHIFT   = 22;
  localparam int DLT_SHIFT  = 24;
  localparam logic [21:0] RECIP_TV  = 22'(((2**TV_SHIFT) + DIAL_MINUTES - 1) / DIAL_MINUTES);
  localparam logic [23:0] RECIP_DLT = 24'(((2**DLT_SHIFT) + DIAL_MINUTES - 1) / DIAL_MINUTES);
  localparam int DELTA_BIAS = DIAL_MINUTES * ((128 + DIAL_MINUTES - 1) / DIAL_MINUTES);

  logic                                    valid;
  logic [sdc_pkg::TIME_W-1:0]              tv;
  logic [sdc_pkg::DELTA_W-1:0]             dl;
  logic [sdc_pkg::DLTU_W-1:0]              dlt_u;
  logic [32:0]                             tv_prod;
  logic [35:0]                             dlt_prod;
  sdc_pkg::item_t                          item_next;

  assign tv       = s_axis_tdata[10:0];
  assign dl       = s_axis_tdata[18:11];
  assign dlt_u    = sdc_pkg::DLTU_W'(DELTA_BIAS) + {{4{dl[7]}}, dl};
  assign tv_prod  = 33'(tv) * 33'(RECIP_TV);
  assign dlt_prod = 36'(dlt_u) * 36'(RECIP_DLT);

  always_comb begin
    item_next.opcode      = sdc_pkg::op_t'(s_axis_tuser);
    item_next.time_value  = tv;
    item_next.tv_quo      = sdc_pkg::TVQ_W'(tv_prod >> TV_SHIFT);
    item_next.dlt_u       = dlt_u;
    item_next.dlt_quo     = sdc_pkg::DLTQ_W'(dlt_prod >> DLT_SHIFT);
    item_next.driver_busy = s_axis_tdata[19];
    item_next.saved_word  = s_axis_tdata[35:20];
  end

  assign fire          = valid && advance;
  assign s_axis_tready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_axis_tready) begin
      valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item <= item_next;
    end
  end

endmodule

### src/sdc_core.sv
// Dial state, wait window register and per-event update logic.
module sdc_core #(
  parameter int DIAL_MINUTES = sdc_pkg::DIAL_MINUTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  input  logic [sdc_pkg::WINDOW_W-1:0]      cfg_data,
  input  logic                              fire,
  input  sdc_pkg::item_t                    item,
  output sdc_pkg::result_t                  result
);

  localparam logic [sdc_pkg::TIME_W-1:0] DIAL      = sdc_pkg::TIME_W'(DIAL_MINUTES);
  localparam logic [sdc_pkg::TIME_W-1:0] DIAL_LAST = sdc_pkg::TIME_W'(DIAL_MINUTES - 1);
  localparam logic [sdc_pkg::DLTU_W-1:0] DIAL_U    = sdc_pkg::DLTU_W'(DIAL_MINUTES);

  sdc_pkg::mode_t                  mode, mode_next;
  logic [sdc_pkg::TIME_W-1:0]      true_time, true_time_next;
  logic [sdc_pkg::TIME_W-1:0]      dial, dial_next;
  logic [sdc_pkg::WORD_W-1:0]      last_saved, last_saved_next;
  logic                            polarity, polarity_next;
  logic                            pending, pending_next;
  logic [sdc_pkg::WINDOW_W-1:0]    wait_window;

  logic [sdc_pkg::TIME_W-1:0]      tv_mod, set_dec, adj_dec, dial_inc, lead;
  logic [sdc_pkg::DLTU_W-1:0]      dlt_rem, shift_sum;
  logic [sdc_pkg::TIME_W-1:0]      shift_time;
  logic [sdc_pkg::WORD_W-1:0]      save_word, sw;
  logic                            do_save;
  sdc_pkg::kind_t                  kind;
  logic                            ppol;
  logic [sdc_pkg::WORD_W-1:0]      store_word;

  assign sw         = item.saved_word;
  assign tv_mod     = item.time_value - sdc_pkg::TIME_W'(item.tv_quo * DIAL);
  assign dlt_rem    = item.dlt_u - sdc_pkg::DLTU_W'(item.dlt_quo * DIAL_U);
  assign shift_sum  = {1'b0, true_time} + dlt_rem;
  assign shift_time = (shift_sum >= DIAL_U) ? sdc_pkg::TIME_W'(shift_sum - DIAL_U)
                                            : shift_sum[sdc_pkg::TIME_W-1:0];
  assign set_dec    = (tv_mod == '0) ? DIAL_LAST : tv_mod - 1'b1;
  assign adj_dec    = (true_time == '0) ? DIAL_LAST : true_time - 1'b1;
  assign dial_inc   = (dial == DIAL_LAST) ? '0 : dial + 1'b1;
  assign lead       = (dial >= true_time) ? dial - true_time : dial + DIAL - true_time;

  always_comb begin
    mode_next       = mode;
    true_time_next  = true_time;
    dial_next       = dial;
    last_saved_next = last_saved;
    polarity_next   = polarity;
    pending_next    = pending;
    kind            = sdc_pkg::KIND_NONE;
    ppol            = 1'b0;
    do_save         = 1'b0;
    store_word      = '0;
    case (item.opcode)
      sdc_pkg::OP_SET: begin
        true_time_next = tv_mod;
        if (mode == sdc_pkg::MODE_INITIAL || mode == sdc_pkg::MODE_SYNCED) begin
          mode_next = sdc_pkg::MODE_SYNCED;
        end else begin
          if (mode == sdc_pkg::MODE_HEADLESS) begin
            dial_next = set_dec;
          end
          mode_next = sdc_pkg::MODE_RUNNING;
          do_save   = 1'b1;
        end
      end
      sdc_pkg::OP_ADJUST: begin
        mode_next = (mode == sdc_pkg::MODE_RUNNING || mode == sdc_pkg::MODE_SYNCED)
                    ? sdc_pkg::MODE_RUNNING : sdc_pkg::MODE_HEADLESS;
        dial_next = adj_dec;
        do_save   = 1'b1;
      end
      sdc_pkg::OP_SHIFT: begin
        true_time_next = shift_time;
      end
      sdc_pkg::OP_STOP: begin
        mode_next = (mode == sdc_pkg::MODE_RUNNING || mode == sdc_pkg::MODE_SYNCED)
                    ? sdc_pkg::MODE_SYNCED : sdc_pkg::MODE_INITIAL;
        do_save   = 1'b1;
      end
      sdc_pkg::OP_TICK: begin
        if ((mode == sdc_pkg::MODE_RUNNING || mode == sdc_pkg::MODE_HEADLESS) &&
            !pending && !item.driver_busy && (lead > {1'b0, wait_window})) begin
          kind          = sdc_pkg::KIND_PULSE;
          ppol          = polarity;
          polarity_next = !polarity;
          pending_next  = 1'b1;
        end
      end
      sdc_pkg::OP_PULSE_DONE: begin
        if (pending) begin
          pending_next = 1'b0;
          dial_next    = dial_inc;
          do_save      = 1'b1;
        end
      end
      sdc_pkg::OP_RESTORE: begin
        last_saved_next = sw;
        if ((sw & sdc_pkg::RESTORE_MASK) == '0) begin
          polarity_next = sw[sdc_pkg::POL_BIT];
          if (sw[sdc_pkg::TIME_W-1:0] < DIAL) begin
            true_time_next = sw[sdc_pkg::TIME_W-1:0];
            dial_next      = sw[sdc_pkg::TIME_W-1:0];
            mode_next      = sdc_pkg::MODE_PENDING;
            kind           = sdc_pkg::KIND_PULSE;
            ppol           = !sw[sdc_pkg::POL_BIT];
          end
        end
      end
      default: begin
      end
    endcase

    save_word = {4'b0, polarity_next,
                 (mode_next == sdc_pkg::MODE_RUNNING || mode_next == sdc_pkg::MODE_PENDING)
                 ? dial_next : sdc_pkg::SAVE_INVALID};
    if (do_save && (save_word != last_saved_next)) begin
      last_saved_next = save_word;
      kind            = sdc_pkg::KIND_STORE;
      store_word      = save_word;
    end
  end

  always_comb begin
    result.result_kind    = kind;
    result.pulse_polarity = ppol;
    result.store_word     = store_word;
    result.mode_now       = mode_next;
    result.time_now       = true_time_next[sdc_pkg::OUT_T_W-1:0];
    result.dial_now       = dial_next[sdc_pkg::OUT_T_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= sdc_pkg::MODE_INITIAL;
      true_time  <= '0;
      dial       <= '0;
      last_saved <= '0;
      polarity   <= 1'b0;
      pending    <= 1'b0;
    end else if (fire) begin
      mode       <= mode_next;
      true_time  <= true_time_next;
      dial       <= dial_next;
      last_saved <= last_saved_next;
      polarity   <= polarity_next;
      pending    <= pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wait_window <= sdc_pkg::WAIT_WINDOW_RST;
    end else if (cfg_valid) begin
      wait_window <= cfg_data;
    end
  end

endmodule

### src/sdc_egress.sv
// Output register driving the result stream.
module sdc_egress (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             fire,
  input  sdc_pkg::result_t                 result,
  output logic                             advance,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [sdc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic [sdc_pkg::OUT_USER_W-1:0]   m_axis_tuser
);

  sdc_pkg::result_t held;

  assign advance = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      held <= result;
    end
  end

  assign m_axis_tuser = held.result_kind;
  assign m_axis_tdata = {held.dial_now, held.time_now, held.mode_now,
                         held.store_word, held.pulse_polarity};

endmodule

### src/slave_clock_dial_controller.sv
// Top level of the slave clock dial controller.
//
// Events enter on the s_axis stream, one transfer per event; every event
// yields exactly one result transfer on m_axis, in order. The user must
// write the wait window through cfg_valid/cfg_data (always ready) only while
// no event is in flight; the block itself does not enforce this.
// Each event passes from the input register through the combinational
// state update into the output register. Throughput: one event per cycle
// while the result stream takes each result.
// Reset (rst, synchronous): mode initial, time, dial, saved word, polarity
// and pending flag cleared, wait window 30, both stream registers empty.
// When m_axis_tready is low the result holds in the output register; one
// more event waits in the input register, then s_axis_tready drops until
// the result is taken.
module slave_clock_dial_controller #(
  parameter int DIAL_MINUTES = sdc_pkg::DIAL_MINUTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sdc_pkg::WINDOW_W-1:0]     cfg_data,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // time_value[10:0], delta[18:11], driver_busy[19], saved_word[35:20], zero fill
  input  logic [sdc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // opcode[2:0]
  input  logic [sdc_pkg::IN_USER_W-1:0]    s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // pulse_polarity[0], store_word[16:1], mode_now[19:17], time_now[29:20], dial_now[39:30]
  output logic [sdc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // result_kind[1:0]
  output logic [sdc_pkg::OUT_USER_W-1:0]   m_axis_tuser
);

  logic             advance;
  logic             fire;
  sdc_pkg::item_t   item;
  sdc_pkg::result_t result;

  assign cfg_ready = 1'b1;

  sdc_ingress #(
    .DIAL_MINUTES (DIAL_MINUTES)
  ) u_ingress (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .advance       (advance),
    .fire          (fire),
    .item          (item)
  );

  sdc_core #(
    .DIAL_MINUTES (DIAL_MINUTES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .item      (item),
    .result    (result)
  );

  sdc_egress u_egress (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .result        (result),
    .advance       (advance),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

### sim/tb_top.sv
// Self-checking bench for the slave clock dial controller: directed event table, then random events.
`timescale 1ns / 1ps

module tb_top;
  import sdc_pkg::*;

  localparam int DIAL = DIAL_MINUTES_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PER_PHASE = 380;
  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam result_t UNTYPED = '0;

  typedef struct {
    logic [2:0]  op;
    logic [10:0] tv;
    logic [7:0]  dl;
    logic        busy;
    logic [15:0] sw;
    logic        typed;
    result_t     res;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [WINDOW_W-1:0]   cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;

  logic    fixed_valid = 1'b0;
  result_t fixed_res = '0;
  bit      src_calm = 1'b0;
  bit      sink_calm = 1'b0;
  int      sink_hold = 0;
  int      cycle_count = 0;
  int      errors = 0;

  mode_t       md;
  int          t_now;
  int          d_now;
  logic [15:0] last_word;
  logic        pol;
  logic        awaiting_done;
  logic [9:0]  window;
  result_t     due_results[$];

  row_t script [0:25] = '{
    '{OP_TICK, 11'd0, 8'h00, 1'b0, 16'h0000, 1'b1,
      '{KIND_NONE, 1'b0, 16'h0, MODE_INITIAL, 10'd0, 10'd0}},
    '{OP_SET, 11'd2047, 8'h80, 1'b1, 16'hffff, 1'b1,
      '{KIND_NONE, 1'b0, 16'h0, MODE_SYNCED, 10'd607, 10'd0}},
    '{OP_SHIFT, 11'd0, 8'h80, 1'b0, 16'h0000, 1'b0, UNTYPED},
    '{OP_SHIFT, 11'd2047, 8'h7f, 1'b0, 16'h0000, 1'b0, UNTYPED},
    '{OP_ADJUST, 11'd0, 8'h00, 1'b0, 16'h0000, 1'b0, UNTYPED},
    '{OP_TICK, 11'd0, 8'h00, 1'b1, 16'h0000, 1'b0, UNTYPED},
    '{OP_TICK, 11'd0, 8'h00, 1'b0, 16'h0000, 1'b0, UNTYPED},
    '{OP_PULSE_DONE, 11'd0, 8'h00, 1'b0, 16'h0000, 1'b0, UNTYPED},
    '{OP_PULSE_DONE, 11'd0, 8'h00, 1'b0, 16'h0000, 1'b0, UNTYPED},
    '{OP_STOP, 11'd0, 8'h00, 1'b0, 16'h0000, 1'b0, UNTYPED},
    '{OP_STOP, 11'd0, 8'h00, 1'b0, 16'h0000, 1'b0, UNTYPED},
    '{OP_SET, 11'd0, 8'h00, 1'b0, 16'h0000, 1'b0, UNTYPED},
    '{OP_ADJUST, 11'd0, 8'h00, 1'b0, 16'h0000, 1'b0, UNTYPED},
    '{OP_SHIFT, 11'd0, 8'h01, 1'b0, 16'h0000, 1'b0, UNTYPED},
    '{OP_TICK, 11'd0, 8'h00, 1'b0, 16'h0000, 1'b0, UNTYPED},
    '{OP_RESTORE, 11'd0, 8'h00, 1'b0, 16'hc000, 1'b0, UNTYPED},
    '{OP_RESTORE, 11'd0, 8'h00, 1'b0, 16'h4abc, 1'b0, UNTYPED},
    '{OP_RESTORE, 11'd0, 8'h00, 1'b0, 16'h0acf, 1'b1,
      '{KIND_PULSE, 1'b0, 16'h0, MODE_PENDING, 10'd719, 10'd719}},
    '{OP_RESTORE, 11'd0, 8'h00, 1'b0, 16'h07ff, 1'b1,
      '{KIND_NONE, 1'b0, 16'h0, MODE_PENDING, 10'd719, 10'd719}},
    '{OP_RESTORE, 11'd0, 8'h00, 1'b0, 16'h02d0, 1'b1,
      '{KIND_NONE, 1'b0, 16'h0, MODE_PENDING, 10'd719, 10'd719}},
    '{OP_ADJUST, 11'd0, 8'h00, 1'b0, 16'h0000, 1'b0, UNTYPED},
    '{OP_PULSE_DONE, 11'd0, 8'h00, 1'b0, 16'h0000, 1'b0, UNTYPED},
    '{OP_SHIFT, 11'd0, 8'h9c, 1'b0, 16'h0000, 1'b0, UNTYPED},
    '{OP_TICK, 11'd0, 8'h00, 1'b0, 16'h0000, 1'b0, UNTYPED},
    '{OP_STOP, 11'd0, 8'h00, 1'b0, 16'h0000, 1'b0, UNTYPED},
    '{OP_UNUSED, 11'd1234, 8'h55, 1'b1, 16'h1234, 1'b0, UNTYPED}
  };

  slave_clock_dial_controller dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #6 clk = ~clk;

  function automatic int wrap(input int v);
    int m;
    m = v % DIAL;
    if (m < 0) m += DIAL;
    return m;
  endfunction

  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // Advance the dial state by one event and return the result it yields.
  function automatic result_t dial_event(input logic [2:0] op, input logic [10:0] tv,
                                         input logic [7:0] dl, input logic busy,
                                         input logic [15:0] sw);
    result_t     r;
    logic        save;
    logic [15:0] w;
    int          pos;
    r = '0;
    save = 1'b0;
    case (op)
      OP_SET: begin
        t_now = wrap(int'(tv));
        if (md == MODE_INITIAL || md == MODE_SYNCED) begin
          md = MODE_SYNCED;
        end else begin
          if (md == MODE_HEADLESS) d_now = wrap(t_now - 1);
          md = MODE_RUNNING;
          save = 1'b1;
        end
      end
      OP_ADJUST: begin
        md = (md == MODE_RUNNING || md == MODE_SYNCED) ? MODE_RUNNING : MODE_HEADLESS;
        d_now = wrap(t_now - 1);
        save = 1'b1;
      end
      OP_SHIFT: begin
        t_now = wrap(t_now + int'($signed(dl)));
      end
      OP_STOP: begin
        md = (md == MODE_RUNNING || md == MODE_SYNCED) ? MODE_SYNCED : MODE_INITIAL;
        save = 1'b1;
      end
      OP_TICK: begin
        if ((md == MODE_RUNNING || md == MODE_HEADLESS) && !awaiting_done && !busy &&
            wrap(d_now - t_now) > int'(window)) begin
          r.result_kind = KIND_PULSE;
          r.pulse_polarity = pol;
          pol = ~pol;
          awaiting_done = 1'b1;
        end
      end
      OP_PULSE_DONE: begin
        if (awaiting_done) begin
          awaiting_done = 1'b0;
          d_now = wrap(d_now + 1);
          save = 1'b1;
        end
      end
      OP_RESTORE: begin
        last_word = sw;
        if ((sw & RESTORE_MASK) == '0) begin
          pos = int'(sw[10:0]);
          if (pos < DIAL) begin
            t_now = pos;
            d_now = pos;
            md = MODE_PENDING;
            r.result_kind = KIND_PULSE;
            r.pulse_polarity = ~sw[POL_BIT];
          end
          pol = sw[POL_BIT];
        end
      end
      default: ;
    endcase
    if (save) begin
      w = {4'b0, pol, (md == MODE_RUNNING || md == MODE_PENDING) ? 11'(d_now) : SAVE_INVALID};
      if (w != last_word) begin
        last_word = w;
        r.result_kind = KIND_STORE;
        r.store_word = w;
      end
    end
    r.mode_now = md;
    r.time_now = 10'(t_now);
    r.dial_now = 10'(d_now);
    return r;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0d ns: %s expected %0d got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) sink_calm <= !sink_calm;
    if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (!sink_calm && $urandom_range(0, 3) == 0) sink_hold <= idle_span();
    end
  end

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst) begin
      md = MODE_INITIAL;
      t_now = 0;
      d_now = 0;
      last_word = '0;
      pol = 1'b0;
      awaiting_done = 1'b0;
      window = WAIT_WINDOW_RST;
      due_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) window = cfg_data;
      if (s_axis_tvalid && s_axis_tready) begin
        want = dial_event(s_axis_tuser, s_axis_tdata[10:0], s_axis_tdata[18:11],
                          s_axis_tdata[19], s_axis_tdata[35:20]);
        due_results.push_back(fixed_valid ? fixed_res : want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.result_kind    = kind_t'(m_axis_tuser);
        got.pulse_polarity = m_axis_tdata[0];
        got.store_word     = m_axis_tdata[16:1];
        got.mode_now       = mode_t'(m_axis_tdata[19:17]);
        got.time_now       = m_axis_tdata[29:20];
        got.dial_now       = m_axis_tdata[39:30];
        if (due_results.size() == 0) begin
          errors++;
          $display("%0d ns: result transfer with none expected, got %h", $time, got);
        end else begin
          want = due_results.pop_front();
          check_field("result_kind", want.result_kind, got.result_kind);
          check_field("pulse_polarity", want.pulse_polarity, got.pulse_polarity);
          check_field("store_word", want.store_word, got.store_word);
          check_field("mode_now", want.mode_now, got.mode_now);
          check_field("time_now", want.time_now, got.time_now);
          check_field("dial_now", want.dial_now, got.dial_now);
        end
      end
    end
  end

  task automatic send_event(input logic [2:0] op, input logic [10:0] tv, input logic [7:0] dl,
                            input logic busy, input logic [15:0] sw, input logic typed,
                            input result_t res);
    int gap;
    if ($urandom_range(0, 39) == 0) src_calm = !src_calm;
    gap = src_calm ? 0 : idle_span();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, sw, busy, dl, tv};
    s_axis_tuser  <= op;
    fixed_valid   <= typed;
    fixed_res     <= res;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic send_random(output bit counted);
    logic [2:0]  op;
    logic [15:0] sw;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 28) op = OP_TICK;
    else if (r < 50) op = OP_PULSE_DONE;
    else if (r < 60) op = OP_SHIFT;
    else if (r < 69) op = OP_SET;
    else if (r < 77) op = OP_ADJUST;
    else if (r < 82) op = OP_STOP;
    else if (r < 98) op = OP_RESTORE;
    else op = OP_UNUSED;
    sw = 16'($urandom);
    if (op == OP_RESTORE) begin
      r = $urandom_range(0, 9);
      if (r < 6) begin
        sw[15:14] = 2'b00;
        sw[10:0] = 11'($urandom_range(0, DIAL - 1));
      end else if (r < 8) begin
        sw[15:14] = 2'($urandom_range(1, 3));
      end else begin
        sw[15:14] = 2'b00;
        sw[10:0] = 11'($urandom_range(DIAL, 2047));
      end
    end
    send_event(op, 11'($urandom_range(0, 2047)), 8'($urandom), ($urandom_range(0, 4) == 0),
               sw, 1'b0, UNTYPED);
    counted = (op != OP_UNUSED);
  endtask

  task automatic write_window(input logic [9:0] v);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int         n;
    int         ph;
    bit         counted;
    logic [9:0] windows [0:4];
    windows[0] = 10'd0;
    windows[1] = 10'd719;
    windows[2] = 10'($urandom_range(0, 719));
    windows[3] = 10'($urandom_range(0, 719));
    windows[4] = 10'd1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (script[i])
      send_event(script[i].op, script[i].tv, script[i].dl, script[i].busy, script[i].sw,
                 script[i].typed, script[i].res);
    for (ph = 0; ph < 5; ph++) begin
      write_window(windows[ph]);
      n = 0;
      while (n < RANDOM_PER_PHASE) begin
        send_random(counted);
        if (counted) n++;
      end
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    for (n = 0; n < 2000 && due_results.size() != 0; n++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (due_results.size() != 0) begin
      errors++;
      $display("%0d ns: %0d results never arrived", $time, due_results.size());
    end
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

### slave_clock_dial_controller.f
src/sdc_pkg.sv
src/sdc_ingress.sv
src/sdc_core.sv
src/sdc_egress.sv
src/slave_clock_dial_controller.sv
sim/tb_top.sv
